// File: src/adex_neuron_update_defines.svh
// Assertion macros shared by the neuron update block
`ifndef ADEX_NEURON_UPDATE_DEFINES_SVH
`define ADEX_NEURON_UPDATE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger
`define ADEX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define ADEX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/adex_pkg.sv
// Types, constants and helper functions for the neuron update block
package adex_pkg;

  localparam int NEURONS     = 1024;
  localparam int SUBSTEPS    = 10;
  localparam int SLOPE_SHIFT = 1;
  localparam int FRAC_BITS   = 16;

  localparam int ADDR_W    = $clog2(NEURONS);
  localparam int SUB_W     = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 4;

  // fraction of the base-2 exponent realigned to 16 bits
  localparam int F16_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int F16_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LEAK      = 4'd0;
  localparam cfg_idx_t REG_REST      = 4'd1;
  localparam cfg_idx_t REG_THRESHOLD = 4'd2;
  localparam cfg_idx_t REG_SPIKE     = 4'd3;
  localparam cfg_idx_t REG_COUPLING  = 4'd4;
  localparam cfg_idx_t REG_INCREMENT = 4'd5;
  localparam cfg_idx_t REG_STEP_CAP  = 4'd6;
  localparam cfg_idx_t REG_STEP_TAU  = 4'd7;

  localparam logic signed [31:0] RST_LEAK      = 32'sd1966080;
  localparam logic signed [31:0] RST_REST      = -32'sd4626842;
  localparam logic signed [31:0] RST_THRESHOLD = -32'sd3303014;
  localparam logic signed [31:0] RST_SPIKE     = 32'sd1310720;
  localparam logic signed [31:0] RST_COUPLING  = 32'sd262144;

  localparam logic signed [31:0] LOG2E_Q30   = 32'sd1549082005;
  localparam logic signed [32:0] EXP_ARG_MAX = 33'(10 * (1 << FRAC_BITS));
  localparam logic signed [32:0] EXP_ARG_MIN = 33'(-16 * (1 << FRAC_BITS));

  typedef struct packed {
    logic [IDX_W-1:0]         neuron_index;
    logic signed [DATA_W-1:0] input_current;
    logic                     disabled;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic                     fired;
    logic signed [DATA_W-1:0] new_voltage;
    logic signed [DATA_W-1:0] new_adaptation;
  } out_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] leak_conductance;
    logic signed [DATA_W-1:0] rest_potential;
    logic signed [DATA_W-1:0] threshold_potential;
    logic signed [DATA_W-1:0] spike_potential;
    logic signed [DATA_W-1:0] subthreshold_coupling;
    logic signed [DATA_W-1:0] spike_increment;
    logic signed [DATA_W-1:0] step_over_capacitance;
    logic signed [DATA_W-1:0] step_over_tau;
  } cfg_regs_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

  // 2^(i/16) in Q16, seventeen points
  function automatic logic [17:0] pow2_frac(input logic [4:0] i);
    logic [17:0] m;
    unique case (i)
      5'd0:    m = 18'd65536;
      5'd1:    m = 18'd68438;
      5'd2:    m = 18'd71468;
      5'd3:    m = 18'd74632;
      5'd4:    m = 18'd77936;
      5'd5:    m = 18'd81386;
      5'd6:    m = 18'd84990;
      5'd7:    m = 18'd88752;
      5'd8:    m = 18'd92682;
      5'd9:    m = 18'd96785;
      5'd10:   m = 18'd101070;
      5'd11:   m = 18'd105545;
      5'd12:   m = 18'd110218;
      5'd13:   m = 18'd115098;
      5'd14:   m = 18'd120194;
      5'd15:   m = 18'd125515;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

// File: src/adex_neuron_update.sv
// Top level: neuron state tables, clearing pass, handshakes and registers
//
//  channel | direction | handshake          | beat
//  in      | input     | in_valid/in_stall  | in_item (index, current, disabled)
//  out     | output    | out_valid/out_stall| out_item (index, fired, voltage, adaptation)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An enabled item runs n substeps (1..SUBSTEPS, fewer on a spike), then its result is
// registered: each substep runs ten sequencer states, seven of them passes through the
// one shared multiplier. in_stall stays high until the result is registered. A disabled
// item is taken and dropped with no result. After reset a clearing pass fills all NEURONS
// entries of the tables; in_stall stays high meanwhile, cfg writes are taken.
// The result register lets the next item in while a beat waits on out_stall.
`include "adex_neuron_update_defines.svh"

module adex_neuron_update import adex_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  cfg_idx_t                 cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {T_CLEAR, T_IDLE, T_READ, T_START, T_RUN} state_t;

  state_t state;
  cfg_regs_t regs;
  logic [ADDR_W-1:0] clr_cnt, slot_r, waddr;
  logic [IDX_W-1:0] idx_r;
  logic signed [DATA_W-1:0] cur_r;
  logic [DATA_W-1:0] v_rdata, a_rdata, v_wdata, a_wdata;
  logic we, store, core_done, core_fired, core_start;
  logic signed [DATA_W-1:0] core_x, core_w;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != T_IDLE);
  assign core_start = (state == T_START);
  assign store      = (state == T_RUN) && core_done && (!out_valid || !out_stall);
  assign we         = (state == T_CLEAR) || store;
  assign waddr      = (state == T_CLEAR) ? clr_cnt : slot_r;
  assign v_wdata    = (state == T_CLEAR) ? RST_REST : core_x;
  assign a_wdata    = (state == T_CLEAR) ? '0 : core_w;

  adex_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_vtab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(v_wdata), .raddr(slot_r), .rdata(v_rdata)
  );

  adex_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_atab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(a_wdata), .raddr(slot_r), .rdata(a_rdata)
  );

  adex_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .ack(store),
    .x_in($signed(v_rdata)), .w_in($signed(a_rdata)), .cur_in(cur_r), .prm(regs),
    .done(core_done), .fired(core_fired), .x_out(core_x), .w_out(core_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leak_conductance      <= RST_LEAK;
      regs.rest_potential        <= RST_REST;
      regs.threshold_potential   <= RST_THRESHOLD;
      regs.spike_potential       <= RST_SPIKE;
      regs.subthreshold_coupling <= RST_COUPLING;
      regs.spike_increment       <= '0;
      regs.step_over_capacitance <= '0;
      regs.step_over_tau         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      // drop writes beyond the register list
      unique case (cfg_index)
        REG_LEAK:      regs.leak_conductance      <= cfg_data;
        REG_REST:      regs.rest_potential        <= cfg_data;
        REG_THRESHOLD: regs.threshold_potential   <= cfg_data;
        REG_SPIKE:     regs.spike_potential       <= cfg_data;
        REG_COUPLING:  regs.subthreshold_coupling <= cfg_data;
        REG_INCREMENT: regs.spike_increment       <= cfg_data;
        REG_STEP_CAP:  regs.step_over_capacitance <= cfg_data;
        REG_STEP_TAU:  regs.step_over_tau         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        T_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(NEURONS - 1)) begin
            state <= T_IDLE;
          end
        end
        T_IDLE: begin
          if (in_valid && !in_item.disabled) begin
            idx_r  <= in_item.neuron_index;
            slot_r <= ADDR_W'(in_item.neuron_index % NEURONS);
            cur_r  <= in_item.input_current;
            state  <= T_READ;
          end
        end
        T_READ:  state <= T_START;
        T_START: state <= T_RUN;
        T_RUN: begin
          if (store) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_CLEAR;
      endcase

      if (store) begin
        out_valid               <= 1'b1;
        out_item.result_index   <= idx_r;
        out_item.fired          <= core_fired;
        out_item.new_voltage    <= core_x;
        out_item.new_adaptation <= core_w;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ADEX_ASSERT_NEXT(a_take_reads, clk, rst,
    in_valid && !in_stall && !in_item.disabled, state == T_READ,
    "enabled beat did not start a table read")
  `ADEX_ASSERT_NOW(a_fire_rest, clk, rst,
    out_valid && out_item.fired, out_item.new_voltage == regs.rest_potential,
    "spike result not at rest potential")
  `ADEX_ASSERT_NOW(a_clear_quiet, clk, rst,
    state == T_CLEAR, !out_valid && !core_done,
    "activity during clearing pass")
  `ADEX_ASSERT_NOW(a_out_from_run, clk, rst,
    $rose(out_valid), $past(state == T_RUN),
    "result appeared outside a run")

endmodule

// File: src/adex_ram.sv
// Generic single-write, single-read RAM with registered read data
module adex_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/adex_mul.sv
// Shared signed 32x32 multiplier with registered product
module adex_mul import adex_pkg::*; (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic signed [63:0]       p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: src/adex_core.sv
// Euler substep sequencer around the shared multiplier
module adex_core import adex_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     ack,
  input  logic signed [DATA_W-1:0] x_in,
  input  logic signed [DATA_W-1:0] w_in,
  input  logic signed [DATA_W-1:0] cur_in,
  input  cfg_regs_t                prm,
  output logic                     done,
  output logic                     fired,
  output logic signed [DATA_W-1:0] x_out,
  output logic signed [DATA_W-1:0] w_out
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_EXPARG, ST_TSPLIT, ST_LIN, ST_MANT,
    ST_ADAPT, ST_SUM, ST_VMUL, ST_WMUL, ST_UPD, ST_DONE
  } step_t;

  step_t step;
  logic [SUB_W-1:0] sub_cnt;
  logic signed [DATA_W-1:0] x, w, cur;
  logic signed [DATA_W-1:0] dv_r, u_r, lin_r, e_r, ad_r, sum_r, drive_r, vinc_r;
  logic signed [7:0] k_r;
  logic [15:0] f16_r;

  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [63:0] prod;

  adex_mul u_mul (.clk(clk), .a(op_a), .b(op_b), .p(prod));

  logic signed [32:0] diff_x, ud, us, u_cl;
  logic signed [DATA_W-1:0] dv_c, prod_sat, lin_c, expp_c, drive_c, xn, wn, wb, e_c;
  logic signed [63:0] t_c, prod_q, neg;
  logic [FRAC_BITS-1:0] tf;
  logic [15:0] f16_c;
  logic [17:0] tbl_lo, tbl_hi, tbl_d, mant;
  logic signed [9:0] s_c;
  logic [63:0] m_sh;
  logic signed [34:0] sum35;

  always_comb begin
    diff_x = 33'(x) - 33'(prm.rest_potential);
    dv_c   = sat32(66'(diff_x));
    ud     = 33'(x) - 33'(prm.threshold_potential);
    us     = ud >>> SLOPE_SHIFT;
    if (us > EXP_ARG_MAX) begin
      u_cl = EXP_ARG_MAX;
    end else if (us < EXP_ARG_MIN) begin
      u_cl = EXP_ARG_MIN;
    end else begin
      u_cl = us;
    end

    t_c   = prod >>> 30;
    tf    = t_c[FRAC_BITS-1:0];
    f16_c = 16'((32'(tf) << F16_UP) >> F16_DN);

    prod_q   = prod >>> FRAC_BITS;
    prod_sat = sat32(66'(prod_q));
    neg      = -prod;
    lin_c    = sat32(66'(neg >>> FRAC_BITS));

    tbl_lo = pow2_frac({1'b0, f16_r[15:12]});
    tbl_hi = pow2_frac({1'b0, f16_r[15:12]} + 5'd1);
    tbl_d  = tbl_hi - tbl_lo;
    mant   = tbl_lo + 18'(prod >> 12);

    // scale the mantissa by the integer part of the base-2 exponent
    s_c = 10'(k_r) + 10'(FRAC_BITS - 16);
    if (s_c >= 0) begin
      m_sh = 64'(mant) << s_c[8:0];
    end else begin
      m_sh = 64'(mant) >> (-s_c);
    end
    e_c = (m_sh > 64'd2147483647) ? 32'sh7FFFFFFF : 32'(m_sh);

    expp_c  = sat32(66'(prod_q) <<< SLOPE_SHIFT);
    sum35   = 35'(lin_r) + 35'(expp_c) - 35'(w) + 35'(cur);
    drive_c = sat32(66'(34'(ad_r) - 34'(w)));

    xn = sat32(66'(33'(x) + 33'(vinc_r)));
    wn = sat32(66'(33'(w) + 33'(prod_sat)));
    wb = sat32(66'(33'(wn) + 33'(prm.spike_increment)));
  end

  always_comb begin
    unique case (step)
      ST_EXPARG: begin
        op_a = u_r;
        op_b = LOG2E_Q30;
      end
      ST_TSPLIT: begin
        op_a = prm.leak_conductance;
        op_b = dv_r;
      end
      ST_LIN: begin
        op_a = {14'd0, tbl_d};
        op_b = {20'd0, f16_r[11:0]};
      end
      ST_MANT: begin
        op_a = prm.subthreshold_coupling;
        op_b = dv_r;
      end
      ST_ADAPT: begin
        op_a = prm.leak_conductance;
        op_b = e_r;
      end
      ST_VMUL: begin
        op_a = sum_r;
        op_b = prm.step_over_capacitance;
      end
      ST_WMUL: begin
        op_a = drive_r;
        op_b = prm.step_over_tau;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      unique case (step)
        ST_IDLE: begin
          if (start) begin
            x       <= x_in;
            w       <= w_in;
            cur     <= cur_in;
            fired   <= 1'b0;
            sub_cnt <= '0;
            step    <= ST_PREP;
          end
        end
        ST_PREP: begin
          dv_r <= dv_c;
          u_r  <= 32'(u_cl);
          step <= ST_EXPARG;
        end
        ST_EXPARG: step <= ST_TSPLIT;
        ST_TSPLIT: begin
          k_r   <= 8'(t_c >>> FRAC_BITS);
          f16_r <= f16_c;
          step  <= ST_LIN;
        end
        ST_LIN: begin
          lin_r <= lin_c;
          step  <= ST_MANT;
        end
        ST_MANT: begin
          e_r  <= e_c;
          step <= ST_ADAPT;
        end
        ST_ADAPT: begin
          ad_r <= prod_sat;
          step <= ST_SUM;
        end
        ST_SUM: begin
          sum_r   <= sat32(66'(sum35));
          drive_r <= drive_c;
          step    <= ST_VMUL;
        end
        ST_VMUL: step <= ST_WMUL;
        ST_WMUL: begin
          vinc_r <= prod_sat;
          step   <= ST_UPD;
        end
        ST_UPD: begin
          if (xn >= prm.spike_potential) begin
            // spike: back to rest, bump adaptation, stop early
            x     <= prm.rest_potential;
            w     <= wb;
            fired <= 1'b1;
            step  <= ST_DONE;
          end else begin
            x <= xn;
            w <= wn;
            if (sub_cnt == SUB_W'(SUBSTEPS - 1)) begin
              step <= ST_DONE;
            end else begin
              sub_cnt <= sub_cnt + 1'b1;
              step    <= ST_PREP;
            end
          end
        end
        ST_DONE: begin
          if (ack) begin
            step <= ST_IDLE;
          end
        end
        default: step <= ST_IDLE;
      endcase
    end
  end

  assign done  = (step == ST_DONE);
  assign x_out = x;
  assign w_out = w;

endmodule
